@@ src/assert_macros.svh @@
// Assertion macros shared by the transcoder RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLT_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLT_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

@@ src/slt_pkg.sv @@
// Package for the string literal transcoder: types, codes and constants.
// Depends on nothing; used by every other RTL file but assert_macros.svh.
`default_nettype none

package slt_pkg;

    localparam int UNIT_W          = 32;
    localparam int BYTE_W          = 8;
    localparam int CNT_OUT_W       = 16;
    localparam int MAX_UNITS       = 4;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int SLOT_W          = 3;

    localparam logic [UNIT_W-1:0] CODE_POINT_MAX = 32'h0010_FFFF;

    localparam logic CMD_BODY = 1'b0;
    localparam logic CMD_END  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_ESC  = 2'd1,
        ST_RANGE    = 2'd2,
        ST_BAD_UTF8 = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PH_NORMAL = 3'd0,
        PH_ESC    = 3'd1,
        PH_OCT    = 3'd2,
        PH_HEX    = 3'd3,
        PH_UESC   = 3'd4,
        PH_UTF8   = 3'd5
    } phase_t;

    // Everything one input item produces, handed from the decoder to the output stage.
    typedef struct packed {
        logic [MAX_UNITS-1:0][UNIT_W-1:0]    units;
        logic [MAX_UNITS-1:0][CNT_OUT_W-1:0] counts;
        logic [SLOT_W-1:0]                   n_units;
        logic                                has_end;
        logic [1:0]                          end_status;
        logic [CNT_OUT_W-1:0]                end_count;
    } bundle_t;

endpackage

`default_nettype wire

@@ src/slt_if.sv @@
// Valid/ready channel interfaces for the transcoder input and output items.
// Depends on slt_pkg for the field widths.
`default_nettype none

interface slt_in_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [slt_pkg::BYTE_W-1:0]  literal_byte;

    modport source (output valid, output cmd, output literal_byte, input ready);
    modport sink   (input valid, input cmd, input literal_byte, output ready);
endinterface

interface slt_out_if;
    logic                          valid;
    logic                          ready;
    logic [slt_pkg::UNIT_W-1:0]    out_unit;
    logic                          is_end;
    logic [1:0]                    status;
    logic [slt_pkg::CNT_OUT_W-1:0] unit_count;
    logic                          last;

    modport source (output valid, output out_unit, output is_end, output status,
                    output unit_count, output last, input ready);
    modport sink   (input valid, input out_unit, input is_end, input status,
                    input unit_count, input last, output ready);
endinterface

`default_nettype wire

@@ src/slt_decoder.sv @@
// Escape and UTF-8 decoder: holds the per-literal state and builds one result bundle per item.
// Depends on slt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module slt_decoder #(
    parameter int COUNT_WIDTH = slt_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       accept,
    input  wire logic                       in_cmd,
    input  wire logic [slt_pkg::BYTE_W-1:0] in_byte,
    input  wire logic                       wide_mode,
    output slt_pkg::bundle_t                bundle,
    output logic                            has_records
);

    typedef struct packed {
        logic [slt_pkg::MAX_UNITS-1:0][slt_pkg::UNIT_W-1:0] units;
        logic [slt_pkg::SLOT_W-1:0]                         len;
    } enc_t;

    slt_pkg::phase_t          phase_reg, phase_next;
    logic [31:0]              acc_reg, acc_next;
    logic [3:0]               dig_reg, dig_next;
    logic [1:0]               u8_reg, u8_next;
    logic                     ovf_reg, ovf_next;
    slt_pkg::status_t         err_reg, err_next;
    logic [COUNT_WIDTH-1:0]   count_reg, count_next;

    logic [4:0]               hexv;
    logic [8:0]               simv;
    logic                     is_oct;
    slt_pkg::status_t         fin_err;
    logic                     take_start;
    slt_pkg::phase_t          st_phase;
    logic [31:0]              st_acc;
    logic [1:0]               st_u8;
    slt_pkg::status_t         st_err;
    logic                     st_cp;
    logic [31:0]              acc_hex;
    logic [31:0]              acc_u8;
    logic                     pre_vld;
    logic [31:0]              pre_val;
    logic                     cp_vld;
    logic [31:0]              cp_val;
    logic                     end_vld;
    slt_pkg::status_t         end_status;
    enc_t                     enc;
    logic [slt_pkg::SLOT_W-1:0] n_units;
    logic [COUNT_WIDTH-1:0]   total_count;

    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] r;
        r = '0;
        if (b >= 8'h30 && b <= 8'h39)      r = {1'b1, 4'(b - 8'h30)};
        else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
        else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
        return r;
    endfunction

    function automatic logic [8:0] simple_esc(input logic [7:0] b);
        logic [8:0] r;
        case (b)
            8'h27:   r = {1'b1, 8'h27};
            8'h22:   r = {1'b1, 8'h22};
            8'h3f:   r = {1'b1, 8'h3f};
            8'h5c:   r = {1'b1, 8'h5c};
            8'h61:   r = {1'b1, 8'h07};
            8'h62:   r = {1'b1, 8'h08};
            8'h66:   r = {1'b1, 8'h0c};
            8'h6e:   r = {1'b1, 8'h0a};
            8'h72:   r = {1'b1, 8'h0d};
            8'h74:   r = {1'b1, 8'h09};
            8'h76:   r = {1'b1, 8'h0b};
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic enc_t utf8_encode(input logic [31:0] v, input logic wide);
        enc_t e;
        e = '0;
        if (wide || v <= 32'h7f) begin
            e.units[0] = v;
            e.len      = 3'd1;
        end else if (v <= 32'h7ff) begin
            e.units[0] = {24'b0, 8'hC0 | {2'b0, v[11:6]}};
            e.units[1] = {24'b0, 8'h80 | {2'b0, v[5:0]}};
            e.len      = 3'd2;
        end else if (v <= 32'hffff) begin
            e.units[0] = {24'b0, 8'hE0 | {2'b0, v[17:12]}};
            e.units[1] = {24'b0, 8'h80 | {2'b0, v[11:6]}};
            e.units[2] = {24'b0, 8'h80 | {2'b0, v[5:0]}};
            e.len      = 3'd3;
        end else begin
            e.units[0] = {24'b0, 8'hF0 | {2'b0, v[23:18]}};
            e.units[1] = {24'b0, 8'h80 | {2'b0, v[17:12]}};
            e.units[2] = {24'b0, 8'h80 | {2'b0, v[11:6]}};
            e.units[3] = {24'b0, 8'h80 | {2'b0, v[5:0]}};
            e.len      = 3'd4;
        end
        return e;
    endfunction

    // Saturating add of a small step; the count never passes all ones.
    function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] base,
                                                      input logic [2:0] step);
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, base} + (COUNT_WIDTH+1)'(step);
        return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
    endfunction

    assign hexv    = hex_val(in_byte);
    assign simv    = simple_esc(in_byte);
    assign is_oct  = (in_byte >= 8'h30) && (in_byte <= 8'h37);
    assign acc_hex = {acc_reg[27:0], hexv[3:0]};
    assign acc_u8  = {acc_reg[25:0], in_byte[5:0]};

    // Closing an octal or hex escape.
    always_comb
    begin
        if (ovf_reg || acc_reg[31])
            fin_err = slt_pkg::ST_BAD_ESC;
        else if (!wide_mode && (acc_reg[31:8] != '0))
            fin_err = slt_pkg::ST_RANGE;
        else
            fin_err = slt_pkg::ST_OK;
    end

    // A byte seen outside any escape or multi-byte sequence.
    always_comb
    begin
        st_phase = slt_pkg::PH_NORMAL;
        st_acc   = '0;
        st_u8    = '0;
        st_err   = slt_pkg::ST_OK;
        st_cp    = 1'b0;
        if (in_byte == 8'h5c) begin
            st_phase = slt_pkg::PH_ESC;
        end else if (!in_byte[7]) begin
            st_cp = 1'b1;
        end else if (in_byte[7:5] == 3'b110) begin
            st_acc   = {27'b0, in_byte[4:0]};
            st_u8    = 2'd1;
            st_phase = slt_pkg::PH_UTF8;
        end else if (in_byte[7:4] == 4'b1110) begin
            st_acc   = {28'b0, in_byte[3:0]};
            st_u8    = 2'd2;
            st_phase = slt_pkg::PH_UTF8;
        end else if (in_byte[7:3] == 5'b11110) begin
            st_acc   = {29'b0, in_byte[2:0]};
            st_u8    = 2'd3;
            st_phase = slt_pkg::PH_UTF8;
        end else begin
            st_err = slt_pkg::ST_BAD_UTF8;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        dig_next   = dig_reg;
        u8_next    = u8_reg;
        ovf_next   = ovf_reg;
        err_next   = err_reg;
        take_start = 1'b0;
        pre_vld    = 1'b0;
        pre_val    = acc_reg;
        cp_vld     = 1'b0;
        cp_val     = {24'b0, in_byte};
        end_vld    = 1'b0;
        end_status = err_reg;
        if (in_cmd == slt_pkg::CMD_BODY) begin
            if (err_reg == slt_pkg::ST_OK) begin
                unique case (phase_reg)
                    slt_pkg::PH_ESC:
                    begin
                        acc_next = '0;
                        ovf_next = 1'b0;
                        if (in_byte == 8'h75 || in_byte == 8'h55) begin
                            dig_next   = (in_byte == 8'h75) ? 4'd4 : 4'd8;
                            phase_next = slt_pkg::PH_UESC;
                        end else if (in_byte == 8'h78) begin
                            dig_next   = 4'd1;
                            phase_next = slt_pkg::PH_HEX;
                        end else if (is_oct) begin
                            acc_next   = {29'b0, in_byte[2:0]};
                            phase_next = slt_pkg::PH_OCT;
                        end else if (simv[8]) begin
                            phase_next = slt_pkg::PH_NORMAL;
                            pre_vld    = 1'b1;
                            pre_val    = {24'b0, simv[7:0]};
                        end else begin
                            err_next   = slt_pkg::ST_BAD_ESC;
                            phase_next = slt_pkg::PH_NORMAL;
                        end
                    end
                    slt_pkg::PH_OCT:
                    begin
                        if (is_oct) begin
                            ovf_next = ovf_reg | (acc_reg[31:29] != '0);
                            acc_next = {acc_reg[28:0], in_byte[2:0]};
                        end else if (fin_err != slt_pkg::ST_OK) begin
                            err_next   = fin_err;
                            phase_next = slt_pkg::PH_NORMAL;
                        end else begin
                            pre_vld    = 1'b1;
                            take_start = 1'b1;
                        end
                    end
                    slt_pkg::PH_HEX:
                    begin
                        if (hexv[4]) begin
                            ovf_next = ovf_reg | (acc_reg[31:24] != '0);
                            acc_next = acc_hex;
                            dig_next = '0;
                        end else if (dig_reg != '0) begin
                            err_next   = slt_pkg::ST_BAD_ESC;
                            phase_next = slt_pkg::PH_NORMAL;
                        end else if (fin_err != slt_pkg::ST_OK) begin
                            err_next   = fin_err;
                            phase_next = slt_pkg::PH_NORMAL;
                        end else begin
                            pre_vld    = 1'b1;
                            take_start = 1'b1;
                        end
                    end
                    slt_pkg::PH_UESC:
                    begin
                        if (!hexv[4] || dig_reg == '0) begin
                            err_next   = slt_pkg::ST_BAD_ESC;
                            phase_next = slt_pkg::PH_NORMAL;
                        end else begin
                            acc_next = acc_hex;
                            dig_next = dig_reg - 4'd1;
                            if (dig_reg == 4'd1) begin
                                phase_next = slt_pkg::PH_NORMAL;
                                if (acc_hex > slt_pkg::CODE_POINT_MAX)
                                    err_next = slt_pkg::ST_BAD_ESC;
                                else begin
                                    cp_vld = 1'b1;
                                    cp_val = acc_hex;
                                end
                            end
                        end
                    end
                    slt_pkg::PH_UTF8:
                    begin
                        if (in_byte[7:6] != 2'b10 || u8_reg == '0) begin
                            err_next   = slt_pkg::ST_BAD_UTF8;
                            phase_next = slt_pkg::PH_NORMAL;
                        end else begin
                            acc_next = acc_u8;
                            u8_next  = u8_reg - 2'd1;
                            if (u8_reg == 2'd1) begin
                                phase_next = slt_pkg::PH_NORMAL;
                                if (acc_u8 > slt_pkg::CODE_POINT_MAX)
                                    err_next = slt_pkg::ST_BAD_UTF8;
                                else begin
                                    cp_vld = 1'b1;
                                    cp_val = acc_u8;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        take_start = 1'b1;
                    end
                endcase
            end
            if (take_start) begin
                phase_next = st_phase;
                acc_next   = st_acc;
                dig_next   = '0;
                u8_next    = st_u8;
                ovf_next   = 1'b0;
                err_next   = st_err;
                cp_vld     = st_cp;
            end
        end else begin
            end_vld = 1'b1;
            if (err_reg == slt_pkg::ST_OK) begin
                unique case (phase_reg)
                    slt_pkg::PH_OCT:
                    begin
                        end_status = fin_err;
                        pre_vld    = (fin_err == slt_pkg::ST_OK);
                    end
                    slt_pkg::PH_HEX:
                    begin
                        if (dig_reg != '0) begin
                            end_status = slt_pkg::ST_BAD_ESC;
                        end else begin
                            end_status = fin_err;
                            pre_vld    = (fin_err == slt_pkg::ST_OK);
                        end
                    end
                    slt_pkg::PH_ESC, slt_pkg::PH_UESC:
                    begin
                        end_status = slt_pkg::ST_BAD_ESC;
                    end
                    slt_pkg::PH_UTF8:
                    begin
                        end_status = slt_pkg::ST_BAD_UTF8;
                    end
                    default:
                    begin
                        end_status = slt_pkg::ST_OK;
                    end
                endcase
            end
            // The end item leaves the block clear for the next literal.
            phase_next = slt_pkg::PH_NORMAL;
            acc_next   = '0;
            dig_next   = '0;
            u8_next    = '0;
            ovf_next   = 1'b0;
            err_next   = slt_pkg::ST_OK;
        end
    end

    // A raw unit may be followed by one code point; that code point is then plain ASCII.
    assign enc     = utf8_encode(cp_val, wide_mode);
    assign n_units = 3'(pre_vld) + (cp_vld ? enc.len : 3'd0);
    assign total_count = sat_add(count_reg, n_units);
    assign count_next  = end_vld ? '0 : total_count;

    always_comb
    begin
        bundle = '0;
        for (int i = 0; i < slt_pkg::MAX_UNITS; i++) begin
            bundle.counts[i] = 16'(sat_add(count_reg, 3'(i + 1)));
            if (!pre_vld)
                bundle.units[i] = enc.units[i];
        end
        if (pre_vld) begin
            bundle.units[0] = pre_val;
            for (int i = 1; i < slt_pkg::MAX_UNITS; i++)
                bundle.units[i] = enc.units[i-1];
        end
        bundle.n_units    = n_units;
        bundle.has_end    = end_vld;
        bundle.end_status = end_status;
        bundle.end_count  = 16'(total_count);
    end

    assign has_records = end_vld || (n_units != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= slt_pkg::PH_NORMAL;
            acc_reg   <= '0;
            dig_reg   <= '0;
            u8_reg    <= '0;
            ovf_reg   <= 1'b0;
            err_reg   <= slt_pkg::ST_OK;
            count_reg <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            dig_reg   <= dig_next;
            u8_reg    <= u8_next;
            ovf_reg   <= ovf_next;
            err_reg   <= err_next;
            count_reg <= count_next;
        end
    end

    `SLT_ASSERT_NXT(a_end_clears, clk, rst_n, accept && in_cmd == slt_pkg::CMD_END,
        count_reg == '0 && err_reg == slt_pkg::ST_OK && phase_reg == slt_pkg::PH_NORMAL)
    `SLT_ASSERT_NXT(a_err_freezes, clk, rst_n,
        accept && in_cmd == slt_pkg::CMD_BODY && err_reg != slt_pkg::ST_OK,
        $stable(count_reg) && $stable(err_reg))
    `SLT_ASSERT_IMP(a_err_silent, clk, rst_n,
        in_cmd == slt_pkg::CMD_BODY && err_reg != slt_pkg::ST_OK, !has_records)

endmodule

`default_nettype wire

@@ src/slt_serializer.sv @@
// Output stage: registers one result bundle and hands its records out one per cycle while ready.
// Depends on slt_pkg, slt_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module slt_serializer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire slt_pkg::bundle_t  bundle_in,
    output logic                   can_load,
    slt_out_if.source              out_ch
);

    slt_pkg::bundle_t             bundle_reg;
    logic                         valid_reg;
    logic [slt_pkg::SLOT_W-1:0]   idx_reg;
    logic [slt_pkg::SLOT_W-1:0]   total;
    logic                         is_unit;
    logic                         last_rec;
    logic                         pop;

    assign total    = bundle_reg.n_units + 3'(bundle_reg.has_end);
    assign is_unit  = idx_reg < bundle_reg.n_units;
    assign last_rec = (idx_reg + 3'd1) == total;
    assign pop      = valid_reg && out_ch.ready;
    assign can_load = !valid_reg || (pop && last_rec);

    assign out_ch.valid      = valid_reg;
    assign out_ch.out_unit   = is_unit ? bundle_reg.units[idx_reg[1:0]] : '0;
    assign out_ch.is_end     = !is_unit;
    assign out_ch.status     = is_unit ? 2'(slt_pkg::ST_OK) : bundle_reg.end_status;
    assign out_ch.unit_count = is_unit ? bundle_reg.counts[idx_reg[1:0]]
                                       : bundle_reg.end_count;
    assign out_ch.last       = last_rec;

    always_ff @(posedge clk)
    begin
        if (load)
            bundle_reg <= bundle_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (pop)
        begin
            if (last_rec)
                valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 3'd1;
        end
    end

    `SLT_ASSERT_IMP(a_idx_in_range, clk, rst_n, valid_reg, idx_reg < total)
    `SLT_ASSERT_NXT(a_stall_holds, clk, rst_n, valid_reg && !out_ch.ready && !load,
        valid_reg && $stable(idx_reg))
    `SLT_ASSERT_NXT(a_load_starts, clk, rst_n, load, valid_reg && idx_reg == '0)

endmodule

`default_nettype wire

@@ src/string_literal_transcoder_unit.sv @@
// An item's first record is registered and shows on the output in the cycle after the
// item is taken; items enter one per cycle while each gives at most one record and the
// receiver is ready. Up to four units, or a unit and the end record, can come of one item;
// the output register is the only limit: a new item enters in the cycle its last record goes.
// Reset (rst_n, asynchronous, active low) clears the decode state, the unit count, the
// output valid flag and the wide_mode register; no clearing pass is needed.
`default_nettype none

module string_literal_transcoder_unit #(
    parameter int COUNT_WIDTH = slt_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_we,
    input  wire logic  cfg_wdata,
    slt_in_if.sink     in_item,
    slt_out_if.source  out_item
);

    // The single configuration register: 1 selects 32-bit code units, 0 narrow bytes.
    logic              wide_mode_reg;

    logic              accept;
    logic              can_load;
    logic              has_records;
    slt_pkg::bundle_t  bundle;

    // The input side is ready whenever the output register is empty or its last record
    // leaves in this cycle; a result that the receiver holds off keeps the input waiting
    // until its last record has gone.
    assign in_item.ready = can_load;
    assign accept        = in_item.valid && can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wide_mode_reg <= 1'b0;
        else if (cfg_we)
            wide_mode_reg <= cfg_wdata;
    end

    // The decoder works on the item as it is accepted: escape and UTF-8 state, error
    // tracking and the saturating unit count all advance in that same cycle, and every
    // record the item causes is gathered into one bundle.
    slt_decoder #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_decoder (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_cmd      (in_item.cmd),
        .in_byte     (in_item.literal_byte),
        .wide_mode   (wide_mode_reg),
        .bundle      (bundle),
        .has_records (has_records)
    );

    // Items that cause no record (a byte inside an escape, or any byte after an error)
    // never occupy the output register.
    slt_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && has_records),
        .bundle_in (bundle),
        .can_load  (can_load),
        .out_ch    (out_item)
    );

endmodule

`default_nettype wire
